>>> src/tscb_pkg.sv
package tscb_pkg;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_WRITE   = 3'd1,
		OP_MOVE    = 3'd2,
		OP_VISIBLE = 3'd3,
		OP_MODE    = 3'd4,
		OP_CLEAR   = 3'd5,
		OP_READ    = 3'd6
	} opcode_t;

	typedef enum logic [2:0] {
		MODE_NORMAL      = 3'd0,
		MODE_INSERT      = 3'd1,
		MODE_INSERT_CAPS = 3'd2,
		MODE_SHIFT       = 3'd3,
		MODE_CAPS        = 3'd4,
		MODE_SPACE       = 3'd5
	} cursor_mode_t;

	typedef enum logic [2:0] {
		REG_BLINK_PERIOD = 3'd0,
		REG_GLYPH_SPACE  = 3'd1,
		REG_GLYPH_CURSOR = 3'd2,
		REG_GLYPH_INSERT = 3'd3,
		REG_GLYPH_INS_CAPS = 3'd4,
		REG_GLYPH_SHIFT  = 3'd5,
		REG_GLYPH_CAPS   = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_GLYPH
	} state_t;

	typedef enum logic {
		KIND_DISPLAY = 1'b0,
		KIND_READ    = 1'b1
	} result_kind_t;

	localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;
	localparam logic [7:0]  GLYPH_SPACE_RST  = 8'd32;
	localparam logic [7:0]  GLYPH_CURSOR_RST = 8'd0;
	localparam logic [7:0]  GLYPH_INSERT_RST = 8'd1;
	localparam logic [7:0]  GLYPH_INS_CAPS_RST = 8'd2;
	localparam logic [7:0]  GLYPH_SHIFT_RST  = 8'd3;
	localparam logic [7:0]  GLYPH_CAPS_RST   = 8'd4;

endpackage

>>> src/text_screen_cursor_blink_unit.sv
// A result with no cell lookup is registered as the command is accepted; one that reads
// the cell memory passes ST_READ and then the output register, and a move with the
// cursor shown adds its glyph from ST_GLYPH after that. Without a lookup the unit takes
// one item a cycle while not busy; a lookup holds busy until its last result is registered.
// Reset: control cleared, registers to defaults at once; every cell reads as the space glyph.
// Results are strobed for one cycle; the receiver cannot stall.
module text_screen_cursor_blink_unit #(
	parameter int COLUMNS = 16,
	parameter int LINES   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [3:0]  col_index,
	input  logic [2:0]  line_index,
	input  logic [7:0]  char_code,
	input  logic        string_start,
	input  logic        visible_value,
	input  logic [2:0]  cursor_mode,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        result_valid,
	output logic        result_kind,
	output logic [3:0]  out_col,
	output logic [2:0]  out_line,
	output logic [7:0]  out_char,
	output logic        last_result
);

	localparam int CELLS = COLUMNS * LINES;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int WCW   = $clog2(COLUMNS + 1);

	tscb_pkg::state_t state_q, state_d;

	logic [15:0] blink_period_q;
	logic [7:0]  glyph_space_q, glyph_cursor_q, glyph_insert_q;
	logic [7:0]  glyph_ins_caps_q, glyph_shift_q, glyph_caps_q;

	logic [7:0]       mem [CELLS];
	logic [CELLS-1:0] mask_q;
	logic [3:0]       cur_col_q;
	logic [2:0]       cur_line_q;
	logic             shown_q;
	logic [2:0]       mode_q;
	logic             phase_q;
	logic [15:0]      tick_q;
	logic [WCW-1:0]   wr_col_q;
	logic [2:0]       wr_line_q;

	logic [7:0] rdata_s1;
	logic       mask_s1;
	logic       kind_s1;
	logic [3:0] col_s1;
	logic [2:0] line_s1;
	logic       last_s1;

	logic             accept;
	tscb_pkg::opcode_t op;
	logic [3:0]       col_sat;
	logic [2:0]       line_sat;
	logic [15:0]      tick_inc;
	logic [15:0]      period_eff;
	logic             blink_hit;
	logic             need_read;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    cur_addr;
	logic [WCW-1:0]   wr_col_eff;
	logic [2:0]       wr_line_eff;
	logic             wr_ok;
	logic [AW-1:0]    waddr;
	logic             mem_we;

	function automatic logic [7:0] mode_glyph(input logic [2:0] m);
		case (m)
			tscb_pkg::MODE_INSERT:      mode_glyph = glyph_insert_q;
			tscb_pkg::MODE_INSERT_CAPS: mode_glyph = glyph_ins_caps_q;
			tscb_pkg::MODE_SHIFT:       mode_glyph = glyph_shift_q;
			tscb_pkg::MODE_CAPS:        mode_glyph = glyph_caps_q;
			tscb_pkg::MODE_SPACE:       mode_glyph = glyph_space_q;
			default:                    mode_glyph = glyph_cursor_q;
		endcase
	endfunction

	assign busy      = (state_q != tscb_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign op        = tscb_pkg::opcode_t'(opcode);

	assign col_sat  = (32'(col_index) >= COLUMNS) ? 4'(COLUMNS - 1) : col_index;
	assign line_sat = (32'(line_index) >= LINES) ? 3'(LINES - 1) : line_index;

	assign tick_inc   = tick_q + 16'd1;
	assign period_eff = (blink_period_q == 16'd0) ? 16'd1 : blink_period_q;
	assign blink_hit  = (tick_inc >= period_eff);

	assign cur_addr = AW'(32'(cur_line_q) * COLUMNS + 32'(cur_col_q));

	assign wr_col_eff  = string_start ? WCW'(col_sat) : wr_col_q;
	assign wr_line_eff = string_start ? line_sat : wr_line_q;
	assign wr_ok       = (32'(wr_col_eff) < COLUMNS) && (32'(wr_line_eff) < LINES);
	assign waddr       = AW'(32'(wr_line_eff) * COLUMNS + 32'(wr_col_eff));
	assign mem_we      = accept && (op == tscb_pkg::OP_WRITE) && wr_ok;

	always_comb begin
		need_read = 1'b0;
		raddr     = cur_addr;
		unique case (op)
			tscb_pkg::OP_TICK:    need_read = blink_hit && shown_q && !phase_q;
			tscb_pkg::OP_MOVE:    need_read = 1'b1;
			tscb_pkg::OP_VISIBLE: need_read = shown_q && !visible_value;
			tscb_pkg::OP_READ: begin
				need_read = 1'b1;
				raddr     = AW'(32'(line_sat) * COLUMNS + 32'(col_sat));
			end
			default: need_read = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tscb_pkg::ST_IDLE:  if (accept && need_read) state_d = tscb_pkg::ST_READ;
			tscb_pkg::ST_READ:  state_d = last_s1 ? tscb_pkg::ST_IDLE : tscb_pkg::ST_GLYPH;
			tscb_pkg::ST_GLYPH: state_d = tscb_pkg::ST_IDLE;
			default:            state_d = tscb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tscb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= char_code;
		end
		if (accept && need_read) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q   <= tscb_pkg::BLINK_PERIOD_RST;
			glyph_space_q    <= tscb_pkg::GLYPH_SPACE_RST;
			glyph_cursor_q   <= tscb_pkg::GLYPH_CURSOR_RST;
			glyph_insert_q   <= tscb_pkg::GLYPH_INSERT_RST;
			glyph_ins_caps_q <= tscb_pkg::GLYPH_INS_CAPS_RST;
			glyph_shift_q    <= tscb_pkg::GLYPH_SHIFT_RST;
			glyph_caps_q     <= tscb_pkg::GLYPH_CAPS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tscb_pkg::cfg_reg_t'(cfg_index))
				tscb_pkg::REG_BLINK_PERIOD:   blink_period_q   <= cfg_data;
				tscb_pkg::REG_GLYPH_SPACE:    glyph_space_q    <= cfg_data[7:0];
				tscb_pkg::REG_GLYPH_CURSOR:   glyph_cursor_q   <= cfg_data[7:0];
				tscb_pkg::REG_GLYPH_INSERT:   glyph_insert_q   <= cfg_data[7:0];
				tscb_pkg::REG_GLYPH_INS_CAPS: glyph_ins_caps_q <= cfg_data[7:0];
				tscb_pkg::REG_GLYPH_SHIFT:    glyph_shift_q    <= cfg_data[7:0];
				tscb_pkg::REG_GLYPH_CAPS:     glyph_caps_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q       <= '0;
			cur_col_q    <= '0;
			cur_line_q   <= '0;
			shown_q      <= 1'b1;
			mode_q       <= tscb_pkg::MODE_NORMAL;
			phase_q      <= 1'b1;
			tick_q       <= '0;
			wr_col_q     <= '0;
			wr_line_q    <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (state_q == tscb_pkg::ST_READ) begin
				result_valid <= 1'b1;
				result_kind  <= kind_s1;
				out_col      <= col_s1;
				out_line     <= line_s1;
				out_char     <= mask_s1 ? rdata_s1 : glyph_space_q;
				last_result  <= last_s1;
			end else if (state_q == tscb_pkg::ST_GLYPH) begin
				result_valid <= 1'b1;
				result_kind  <= tscb_pkg::KIND_DISPLAY;
				out_col      <= cur_col_q;
				out_line     <= cur_line_q;
				out_char     <= mode_glyph(mode_q);
				last_result  <= 1'b1;
			end else if (accept) begin
				if (need_read) begin
					mask_s1 <= mask_q[raddr];
					kind_s1 <= (op == tscb_pkg::OP_READ) ? tscb_pkg::KIND_READ
						: tscb_pkg::KIND_DISPLAY;
					col_s1  <= (op == tscb_pkg::OP_READ) ? col_sat : cur_col_q;
					line_s1 <= (op == tscb_pkg::OP_READ) ? line_sat : cur_line_q;
					last_s1 <= !((op == tscb_pkg::OP_MOVE) && shown_q);
				end
				unique case (op)
					tscb_pkg::OP_TICK: begin
						if (blink_hit) begin
							tick_q <= '0;
							if (shown_q) begin
								phase_q <= !phase_q;
								if (phase_q) begin
									result_valid <= 1'b1;
									result_kind  <= tscb_pkg::KIND_DISPLAY;
									out_col      <= cur_col_q;
									out_line     <= cur_line_q;
									out_char     <= mode_glyph(mode_q);
									last_result  <= 1'b1;
								end
							end
						end else begin
							tick_q <= tick_inc;
						end
					end
					tscb_pkg::OP_WRITE: begin
						wr_col_q  <= wr_col_eff;
						wr_line_q <= wr_line_eff;
						if (wr_ok) begin
							mask_q[waddr] <= 1'b1;
							wr_col_q      <= wr_col_eff + WCW'(1);
						end
					end
					tscb_pkg::OP_MOVE: begin
						cur_col_q  <= col_sat;
						cur_line_q <= line_sat;
						phase_q    <= !shown_q;
						tick_q     <= '0;
					end
					tscb_pkg::OP_VISIBLE: begin
						if (visible_value != shown_q) begin
							shown_q <= visible_value;
							if (visible_value) begin
								phase_q      <= 1'b0;
								tick_q       <= '0;
								result_valid <= 1'b1;
								result_kind  <= tscb_pkg::KIND_DISPLAY;
								out_col      <= cur_col_q;
								out_line     <= cur_line_q;
								out_char     <= mode_glyph(mode_q);
								last_result  <= 1'b1;
							end
						end
					end
					tscb_pkg::OP_MODE: begin
						if (cursor_mode != mode_q) begin
							mode_q  <= cursor_mode;
							phase_q <= !shown_q;
							tick_q  <= '0;
							if (shown_q) begin
								result_valid <= 1'b1;
								result_kind  <= tscb_pkg::KIND_DISPLAY;
								out_col      <= cur_col_q;
								out_line     <= cur_line_q;
								out_char     <= mode_glyph(cursor_mode);
								last_result  <= 1'b1;
							end
						end
					end
					tscb_pkg::OP_CLEAR: mask_q <= '0;
					default: ;
				endcase
			end
		end
	end

	a_read_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tscb_pkg::ST_READ) |=> result_valid)
		else $error("cell lookup gave no result");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_result) |=> (result_valid && last_result))
		else $error("non-final result not followed by final one");

	a_read_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind) |-> last_result)
		else $error("read data not marked final");

	a_clear_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == tscb_pkg::OP_CLEAR)) |=> (mask_q == '0))
		else $error("written mask not cleared");

endmodule

>>> tb/sv/text_screen_cursor_blink_unit_tb.sv
module text_screen_cursor_blink_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_UNUSED  = 3'd7;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 250;

	typedef struct packed {
		logic       kind;
		logic [3:0] col;
		logic [2:0] row;
		logic [7:0] code;
		logic       last;
	} screen_event_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [3:0] col;
		logic [2:0] row;
		logic [7:0] code;
		logic       str_start;
		logic       vis;
		logic [2:0] mode;
	} screen_cmd_t;

	class cursor_screen_tracker;
		bit [15:0] period_reg;
		bit [7:0] space_g, cursor_g, insert_g, ins_caps_g, shift_g, caps_g;
		bit [7:0] cells [128];
		bit [127:0] written;
		bit [3:0] cur_col;
		bit [2:0] cur_row;
		bit shown;
		bit [2:0] mode;
		bit phase;
		bit [15:0] ticks;
		bit [4:0] wcol;
		bit [2:0] wrow;
		screen_event_t step_q[$];
		screen_event_t display_due[$];
		int errors;

		function new();
			period_reg = tscb_pkg::BLINK_PERIOD_RST;
			space_g = tscb_pkg::GLYPH_SPACE_RST;
			cursor_g = tscb_pkg::GLYPH_CURSOR_RST;
			insert_g = tscb_pkg::GLYPH_INSERT_RST;
			ins_caps_g = tscb_pkg::GLYPH_INS_CAPS_RST;
			shift_g = tscb_pkg::GLYPH_SHIFT_RST;
			caps_g = tscb_pkg::GLYPH_CAPS_RST;
			written = '0;
			cur_col = '0;
			cur_row = '0;
			shown = 1'b1;
			mode = tscb_pkg::MODE_NORMAL;
			phase = 1'b1;
			ticks = '0;
			wcol = '0;
			wrow = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				tscb_pkg::REG_BLINK_PERIOD:   period_reg = data;
				tscb_pkg::REG_GLYPH_SPACE:    space_g = data[7:0];
				tscb_pkg::REG_GLYPH_CURSOR:   cursor_g = data[7:0];
				tscb_pkg::REG_GLYPH_INSERT:   insert_g = data[7:0];
				tscb_pkg::REG_GLYPH_INS_CAPS: ins_caps_g = data[7:0];
				tscb_pkg::REG_GLYPH_SHIFT:    shift_g = data[7:0];
				tscb_pkg::REG_GLYPH_CAPS:     caps_g = data[7:0];
				default: ;
			endcase
		endfunction

		function bit [7:0] cell_value(bit [3:0] col, bit [2:0] row);
			return written[{row, col}] ? cells[{row, col}] : space_g;
		endfunction

		function bit [7:0] mode_glyph();
			case (mode)
				tscb_pkg::MODE_INSERT:      return insert_g;
				tscb_pkg::MODE_INSERT_CAPS: return ins_caps_g;
				tscb_pkg::MODE_SHIFT:       return shift_g;
				tscb_pkg::MODE_CAPS:        return caps_g;
				tscb_pkg::MODE_SPACE:       return space_g;
				default:                    return cursor_g;
			endcase
		endfunction

		function void add_event(bit kind, bit [3:0] col, bit [2:0] row, bit [7:0] code);
			step_q.push_back('{kind, col, row, code, 1'b0});
		endfunction

		function void blink();
			if (shown) begin
				add_event(tscb_pkg::KIND_DISPLAY, cur_col, cur_row,
					phase ? mode_glyph() : cell_value(cur_col, cur_row));
				phase = ~phase;
			end
		endfunction

		function void restart_blink();
			phase = 1'b1;
			blink();
			ticks = '0;
		endfunction

		function void note_command(screen_cmd_t c);
			bit [15:0] per;
			screen_event_t ev;
			step_q.delete();
			case (c.opcode)
				tscb_pkg::OP_TICK: begin
					per = (period_reg == 0) ? 16'd1 : period_reg;
					ticks = ticks + 16'd1;
					if (ticks >= per) begin
						ticks = '0;
						blink();
					end
				end
				tscb_pkg::OP_WRITE: begin
					if (c.str_start) begin
						wcol = {1'b0, c.col};
						wrow = c.row;
					end
					// past the last column the character is dropped
					if (wcol < 5'd16) begin
						cells[{wrow, wcol[3:0]}] = c.code;
						written[{wrow, wcol[3:0]}] = 1'b1;
						wcol = wcol + 5'd1;
					end
				end
				tscb_pkg::OP_MOVE: begin
					add_event(tscb_pkg::KIND_DISPLAY, cur_col, cur_row,
						cell_value(cur_col, cur_row));
					cur_col = c.col;
					cur_row = c.row;
					restart_blink();
				end
				tscb_pkg::OP_VISIBLE: begin
					if (c.vis != shown) begin
						shown = c.vis;
						if (!c.vis)
							add_event(tscb_pkg::KIND_DISPLAY, cur_col, cur_row,
								cell_value(cur_col, cur_row));
						else
							restart_blink();
					end
				end
				tscb_pkg::OP_MODE: begin
					if (c.mode != mode) begin
						mode = c.mode;
						restart_blink();
					end
				end
				tscb_pkg::OP_CLEAR: written = '0;
				tscb_pkg::OP_READ: add_event(tscb_pkg::KIND_READ, c.col, c.row,
					cell_value(c.col, c.row));
				default: ;
			endcase
			foreach (step_q[i]) begin
				ev = step_q[i];
				ev.last = (i == step_q.size() - 1);
				display_due.push_back(ev);
			end
		endfunction

		function void check_event(screen_event_t got);
			screen_event_t exp;
			if (display_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: kind=%0d col=%0d row=%0d",
						got.kind, got.col, got.row,
						" code=%h last=%0d", got.code, got.last);
				return;
			end
			exp = display_due.pop_front();
			if (got.kind !== exp.kind || got.col !== exp.col || got.row !== exp.row ||
					got.code !== exp.code || got.last !== exp.last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp kind=%0d col=%0d row=%0d code=%h last=%0d,",
						exp.kind, exp.col, exp.row, exp.code, exp.last,
						" got kind=%0d col=%0d row=%0d code=%h last=%0d",
						got.kind, got.col, got.row, got.code, got.last);
			end
		endfunction

		function int pending();
			return display_due.size();
		endfunction

		function void check_drained();
			if (display_due.size() != 0) begin
				errors++;
				if (errors <= 10)
					$display("%0d results never arrived", display_due.size());
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  opcode = '0;
	logic [3:0]  col_index = '0;
	logic [2:0]  line_index = '0;
	logic [7:0]  char_code = '0;
	logic        string_start = 1'b0;
	logic        visible_value = 1'b0;
	logic [2:0]  cursor_mode = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        result_valid;
	logic        result_kind;
	logic [3:0]  out_col;
	logic [2:0]  out_line;
	logic [7:0]  out_char;
	logic        last_result;

	cursor_screen_tracker screen = new();
	bit no_idle = 1'b0;
	int cycle_count = 0;

	text_screen_cursor_blink_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.col_index(col_index),
		.line_index(line_index),
		.char_code(char_code),
		.string_start(string_start),
		.visible_value(visible_value),
		.cursor_mode(cursor_mode),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result_kind(result_kind),
		.out_col(out_col),
		.out_line(out_line),
		.out_char(out_char),
		.last_result(last_result)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid)
			screen.check_event('{result_kind, out_col, out_line, out_char, last_result});
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic screen_cmd_t make_cmd(logic [2:0] op, logic [3:0] col, logic [2:0] row,
			logic [7:0] code, logic st, logic vis, logic [2:0] md);
		return '{op, col, row, code, st, vis, md};
	endfunction

	function automatic screen_cmd_t rand_cmd();
		return '{3'($urandom), 4'($urandom), 3'($urandom), 8'($urandom),
			1'($urandom), 1'($urandom), 3'($urandom)};
	endfunction

	task automatic send_cmd(screen_cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= c.opcode;
		col_index <= c.col;
		line_index <= c.row;
		char_code <= c.code;
		string_start <= c.str_start;
		visible_value <= c.vis;
		cursor_mode <= c.mode;
		@(posedge clk);
		while (busy) @(posedge clk);
		screen.note_command(c);
	endtask

	// wait out pending results plus the tail of items that produce none
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (screen.pending() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		screen.write_reg(idx, data);
	endtask

	function automatic logic [15:0] glyph_value(int style);
		case (style)
			1: return 16'hFFFF;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic program_regs(logic [15:0] period, int style, bit poke_unused);
		drain();
		write_cfg(tscb_pkg::REG_BLINK_PERIOD, period);
		write_cfg(tscb_pkg::REG_GLYPH_SPACE, glyph_value(style));
		write_cfg(tscb_pkg::REG_GLYPH_CURSOR, glyph_value(style));
		write_cfg(tscb_pkg::REG_GLYPH_INSERT, glyph_value(style));
		write_cfg(tscb_pkg::REG_GLYPH_INS_CAPS, glyph_value(style));
		write_cfg(tscb_pkg::REG_GLYPH_SHIFT, glyph_value(style));
		write_cfg(tscb_pkg::REG_GLYPH_CAPS, glyph_value(style));
		if (poke_unused)
			write_cfg(REG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int count);
		screen_cmd_t c;
		int left;
		int r;
		left = 0;
		repeat (count) begin
			c = rand_cmd();
			r = $urandom_range(0, 99);
			if (left > 0 && r < 85) begin
				c.opcode = tscb_pkg::OP_WRITE;
				c.str_start = 1'b0;
				left--;
			end else begin
				left = 0;
				r = $urandom_range(0, 99);
				if (r < 38)
					c.opcode = tscb_pkg::OP_TICK;
				else if (r < 55) begin
					c.opcode = tscb_pkg::OP_WRITE;
					c.str_start = 1'b1;
					left = $urandom_range(0, 18);
				end else if (r < 58) begin
					c.opcode = tscb_pkg::OP_WRITE;
					c.str_start = 1'b0;
				end else if (r < 68)
					c.opcode = tscb_pkg::OP_READ;
				else if (r < 76)
					c.opcode = tscb_pkg::OP_MOVE;
				else if (r < 83) begin
					c.opcode = tscb_pkg::OP_VISIBLE;
					c.vis = ($urandom_range(0, 9) < 7);
				end else if (r < 91)
					c.opcode = tscb_pkg::OP_MODE;
				else if (r < 94)
					c.opcode = tscb_pkg::OP_CLEAR;
				else if (r < 96)
					c.opcode = OP_UNUSED;
				else
					c.opcode = tscb_pkg::OP_READ;
			end
			send_cmd(c);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset register values
		send_cmd(make_cmd(tscb_pkg::OP_WRITE, 4'd9, 3'd3, 8'h41, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_WRITE, 4'd0, 3'd0, 8'hFF, 1'b0, 1'b1, 3'd7));
		send_cmd(make_cmd(tscb_pkg::OP_READ, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_READ, 4'd15, 3'd7, 8'hFF, 1'b1, 1'b1, 3'd7));
		send_cmd(make_cmd(tscb_pkg::OP_WRITE, 4'd14, 3'd7, 8'h00, 1'b1, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_WRITE, 4'd0, 3'd0, 8'h80, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_WRITE, 4'd0, 3'd0, 8'h55, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_WRITE, 4'd15, 3'd7, 8'hAA, 1'b0, 1'b1, 3'd7));
		send_cmd(make_cmd(tscb_pkg::OP_READ, 4'd15, 3'd7, 8'h00, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_MOVE, 4'd15, 3'd7, 8'h00, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_MODE, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0, 3'd6));
		send_cmd(make_cmd(tscb_pkg::OP_MODE, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0, 3'd7));
		send_cmd(make_cmd(tscb_pkg::OP_MODE, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0,
			tscb_pkg::MODE_SPACE));
		send_cmd(make_cmd(tscb_pkg::OP_MODE, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0,
			tscb_pkg::MODE_SPACE));
		send_cmd(make_cmd(tscb_pkg::OP_VISIBLE, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_VISIBLE, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_TICK, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_MODE, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0,
			tscb_pkg::MODE_INSERT));
		send_cmd(make_cmd(tscb_pkg::OP_VISIBLE, 4'd0, 3'd0, 8'h00, 1'b0, 1'b1, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_CLEAR, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_READ, 4'd15, 3'd7, 8'h00, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_READ, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(OP_UNUSED, 4'd15, 3'd7, 8'hFF, 1'b1, 1'b1, 3'd7));
		send_cmd(make_cmd(tscb_pkg::OP_MOVE, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0, 3'd0));
		send_cmd(make_cmd(tscb_pkg::OP_TICK, 4'd0, 3'd0, 8'h00, 1'b0, 1'b0, 3'd0));

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: program_regs(16'd0, 1, 1'b0);
				1: program_regs(16'd1, 0, 1'b0);
				2: program_regs(16'd2, 2, 1'b1);
				3: program_regs(16'hFFFF, 0, 1'b0);
				4: program_regs(16'($urandom_range(1, 6)), 0, 1'b0);
				5: program_regs(16'd3, 0, 1'b0);
				6: program_regs(16'($urandom_range(1, 12)), 0, 1'b0);
				default: program_regs(16'd1, 1, 1'b0);
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			run_random(PHASE_ITEMS);
		end

		drain();
		screen.check_drained();
		if (screen.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> text_screen_cursor_blink_unit.f
src/tscb_pkg.sv
src/text_screen_cursor_blink_unit.sv
tb/sv/text_screen_cursor_blink_unit_tb.sv
